@@ src/ecpa_pkg.sv @@
`default_nettype none
package ecpa_pkg;

   localparam int COORD_BITS = 16;
   localparam int CNT_BITS = $clog2(COORD_BITS);
   localparam int QUEUE_DEPTH = 2;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_COEFF_A = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MODULUS = 1'd1;

   localparam logic [COORD_BITS-1:0] COEFF_A_RESET = COORD_BITS'(0);
   localparam logic [COORD_BITS-1:0] MODULUS_RESET = COORD_BITS'(65521);

   typedef logic [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      coord_type px;
      coord_type py;
      coord_type qx;
      coord_type qy;
   } req_type;

   typedef struct packed {
      coord_type sum_x;
      coord_type sum_y;
      logic      at_infinity;
      logic      no_inverse;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_CLASSIFY,
      ST_SQUARE,
      ST_EU_TEST,
      ST_EU_DIV,
      ST_EU_MUL,
      ST_LAMBDA,
      ST_LAMBDA_SQ,
      ST_Y_MUL,
      ST_OUTPUT
   } back_state_type;

   // operands below m
   function automatic coord_type mod_add(coord_type x, coord_type y, coord_type m);
      logic [COORD_BITS:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= {1'b0, m}) begin
         s = s - {1'b0, m};
      end
      return s[COORD_BITS-1:0];
   endfunction

   function automatic coord_type mod_sub(coord_type x, coord_type y, coord_type m);
      coord_type d;
      d = x - y;
      if (x < y) begin
         d = d + m;
      end
      return d;
   endfunction

endpackage
`default_nettype wire

@@ src/ecpa_front.sv @@
`default_nettype none
module ecpa_front #(
   parameter int DEPTH = ecpa_pkg::QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire ecpa_pkg::req_type req_data,
   output logic                  item_valid,
   output ecpa_pkg::req_type     item_data,
   input  wire logic             item_pop
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
   localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

   ecpa_pkg::req_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic push, pop;

   assign req_stall  = (count_ff == CNT_FULL);
   assign item_valid = (count_ff != '0);
   assign item_data  = mem_ff[rd_ptr_ff];
   assign push = req_valid && !req_stall;
   assign pop  = item_pop && item_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= req_data;
      end
   end

endmodule
`default_nettype wire

@@ src/ecpa_back.sv @@
`default_nettype none
module ecpa_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                item_valid,
   input  wire ecpa_pkg::req_type   item_data,
   output logic                     item_pop,
   input  wire ecpa_pkg::coord_type coeff_a,
   input  wire ecpa_pkg::coord_type modulus,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output ecpa_pkg::rsp_type        rsp_data
);

   localparam int N = ecpa_pkg::COORD_BITS;
   localparam int CW = ecpa_pkg::CNT_BITS;
   localparam logic [CW-1:0] CNT_LAST = CW'(N - 1);
   localparam logic [2:0] RED_LAST = 3'd4;

   ecpa_pkg::back_state_type state_ff, state_in;

   ecpa_pkg::req_type  in_ff, in_in;
   ecpa_pkg::coord_type p_ff, p_in;
   ecpa_pkg::coord_type red_ff [5];
   ecpa_pkg::coord_type red_in [5];
   logic [2:0] red_idx_ff, red_idx_in, red_idx_nx;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [N:0] dv_rem_ff, dv_rem_in;
   ecpa_pkg::coord_type dv_quo_ff, dv_quo_in;
   ecpa_pkg::coord_type mm_acc_ff, mm_acc_in, mm_x_ff, mm_x_in, mm_y_ff, mm_y_in;
   ecpa_pkg::coord_type num_ff, num_in, lam_ff, lam_in;
   ecpa_pkg::coord_type r0_ff, r0_in, r1_ff, r1_in, t0_ff, t0_in, t1_ff, t1_in;
   ecpa_pkg::coord_type x3_ff, x3_in, y3_ff, y3_in;
   logic inf_ff, inf_in, noinv_ff, noinv_in;
   logic rsp_valid_ff;
   ecpa_pkg::rsp_type rsp_ff;

   logic last, out_free, rsp_load, is_inf, is_same;
   ecpa_pkg::coord_type x1, y1, x2, y2, a_red;
   ecpa_pkg::coord_type divisor, mm_acc_nx, mm_x_nx, mm_y_nx, dv_quo_nx;
   ecpa_pkg::coord_type red_src, sq_t, q_red, x3_v;
   logic [N:0] dv_shift, dv_rem_nx;
   logic dv_ge;

   assign x1    = red_ff[0];
   assign y1    = red_ff[1];
   assign x2    = red_ff[2];
   assign y2    = red_ff[3];
   assign a_red = red_ff[4];

   assign last     = (cnt_ff == CNT_LAST);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign is_same  = (x1 == x2) && (y1 == y2);
   assign is_inf   = (x1 == x2) && (ecpa_pkg::mod_add(y1, y2, p_ff) == '0);

   // restoring divider step
   assign divisor   = (state_ff == ecpa_pkg::ST_REDUCE) ? p_ff : r1_ff;
   assign dv_shift  = {dv_rem_ff[N-1:0], dv_quo_ff[N-1]};
   assign dv_ge     = (dv_shift >= {1'b0, divisor});
   assign dv_rem_nx = dv_ge ? dv_shift - {1'b0, divisor} : dv_shift;
   assign dv_quo_nx = {dv_quo_ff[N-2:0], dv_ge};

   // shift-add modular multiplier step, multiplier lsb first
   assign mm_acc_nx = mm_y_ff[0] ? ecpa_pkg::mod_add(mm_acc_ff, mm_x_ff, p_ff) : mm_acc_ff;
   assign mm_x_nx   = ecpa_pkg::mod_add(mm_x_ff, mm_x_ff, p_ff);
   assign mm_y_nx   = mm_y_ff >> 1;

   assign red_idx_nx = red_idx_ff + 3'd1;
   assign sq_t  = mm_acc_nx;
   assign q_red = (dv_quo_nx >= p_ff) ? dv_quo_nx - p_ff : dv_quo_nx;
   assign x3_v  = ecpa_pkg::mod_sub(ecpa_pkg::mod_sub(mm_acc_nx, x1, p_ff), x2, p_ff);

   always_comb begin
      case (red_idx_nx)
         3'd1:    red_src = in_ff.py;
         3'd2:    red_src = in_ff.qx;
         3'd3:    red_src = in_ff.qy;
         default: red_src = coeff_a;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ecpa_pkg::ST_IDLE:      if (item_valid) state_in = ecpa_pkg::ST_REDUCE;
         ecpa_pkg::ST_REDUCE: begin
            if (last && red_idx_ff == RED_LAST) state_in = ecpa_pkg::ST_CLASSIFY;
         end
         ecpa_pkg::ST_CLASSIFY: begin
            if (is_inf) state_in = ecpa_pkg::ST_OUTPUT;
            else if (is_same) state_in = ecpa_pkg::ST_SQUARE;
            else state_in = ecpa_pkg::ST_EU_TEST;
         end
         ecpa_pkg::ST_SQUARE:    if (last) state_in = ecpa_pkg::ST_EU_TEST;
         ecpa_pkg::ST_EU_TEST: begin
            state_in = (r1_ff == '0) ? ecpa_pkg::ST_LAMBDA : ecpa_pkg::ST_EU_DIV;
         end
         ecpa_pkg::ST_EU_DIV:    if (last) state_in = ecpa_pkg::ST_EU_MUL;
         ecpa_pkg::ST_EU_MUL:    if (last) state_in = ecpa_pkg::ST_EU_TEST;
         ecpa_pkg::ST_LAMBDA:    if (last) state_in = ecpa_pkg::ST_LAMBDA_SQ;
         ecpa_pkg::ST_LAMBDA_SQ: if (last) state_in = ecpa_pkg::ST_Y_MUL;
         ecpa_pkg::ST_Y_MUL:     if (last) state_in = ecpa_pkg::ST_OUTPUT;
         ecpa_pkg::ST_OUTPUT:    if (out_free) state_in = ecpa_pkg::ST_IDLE;
         default:                state_in = ecpa_pkg::ST_IDLE;
      endcase
   end

   // fsm outputs
   always_comb begin
      item_pop = 1'b0;
      rsp_load = 1'b0;
      case (state_ff)
         ecpa_pkg::ST_IDLE:   item_pop = item_valid;
         ecpa_pkg::ST_OUTPUT: rsp_load = out_free;
         default: begin
            item_pop = 1'b0;
            rsp_load = 1'b0;
         end
      endcase
   end

   // datapath
   always_comb begin
      in_in      = in_ff;
      p_in       = p_ff;
      red_in     = red_ff;
      red_idx_in = red_idx_ff;
      cnt_in     = '0;
      dv_rem_in  = dv_rem_ff;
      dv_quo_in  = dv_quo_ff;
      mm_acc_in  = mm_acc_ff;
      mm_x_in    = mm_x_ff;
      mm_y_in    = mm_y_ff;
      num_in     = num_ff;
      lam_in     = lam_ff;
      r0_in      = r0_ff;
      r1_in      = r1_ff;
      t0_in      = t0_ff;
      t1_in      = t1_ff;
      x3_in      = x3_ff;
      y3_in      = y3_ff;
      inf_in     = inf_ff;
      noinv_in   = noinv_ff;
      case (state_ff)
         ecpa_pkg::ST_IDLE: begin
            if (item_valid) begin
               in_in      = item_data;
               p_in       = (modulus < N'(2)) ? N'(1) : modulus;
               red_idx_in = '0;
               dv_quo_in  = item_data.px;
               dv_rem_in  = '0;
            end
         end
         ecpa_pkg::ST_REDUCE: begin
            cnt_in    = last ? '0 : cnt_ff + 1'b1;
            dv_rem_in = dv_rem_nx;
            dv_quo_in = dv_quo_nx;
            if (last) begin
               red_in[red_idx_ff] = dv_rem_nx[N-1:0];
               red_idx_in = red_idx_nx;
               dv_rem_in  = '0;
               dv_quo_in  = red_src;
            end
         end
         ecpa_pkg::ST_CLASSIFY: begin
            inf_in   = is_inf;
            noinv_in = 1'b0;
            x3_in    = '0;
            y3_in    = '0;
            mm_x_in  = x1;
            mm_y_in  = x1;
            mm_acc_in = '0;
            num_in   = ecpa_pkg::mod_sub(y2, y1, p_ff);
            r0_in    = p_ff;
            r1_in    = ecpa_pkg::mod_sub(x2, x1, p_ff);
            t0_in    = '0;
            t1_in    = N'(1);
         end
         ecpa_pkg::ST_SQUARE: begin
            cnt_in    = last ? '0 : cnt_ff + 1'b1;
            mm_acc_in = mm_acc_nx;
            mm_x_in   = mm_x_nx;
            mm_y_in   = mm_y_nx;
            if (last) begin
               num_in = ecpa_pkg::mod_add(ecpa_pkg::mod_add(ecpa_pkg::mod_add(sq_t, sq_t, p_ff),
                        sq_t, p_ff), a_red, p_ff);
               r0_in  = p_ff;
               r1_in  = ecpa_pkg::mod_add(y1, y1, p_ff);
               t0_in  = '0;
               t1_in  = N'(1);
            end
         end
         ecpa_pkg::ST_EU_TEST: begin
            if (r1_ff == '0) begin
               noinv_in  = (r0_ff != N'(1));
               mm_x_in   = num_ff;
               mm_y_in   = (r0_ff == N'(1)) ? t0_ff : '0;
               mm_acc_in = '0;
            end else begin
               dv_quo_in = r0_ff;
               dv_rem_in = '0;
            end
         end
         ecpa_pkg::ST_EU_DIV: begin
            cnt_in    = last ? '0 : cnt_ff + 1'b1;
            dv_rem_in = dv_rem_nx;
            dv_quo_in = dv_quo_nx;
            if (last) begin
               mm_x_in   = q_red;
               mm_y_in   = t1_ff;
               mm_acc_in = '0;
               r0_in     = r1_ff;
               r1_in     = dv_rem_nx[N-1:0];
            end
         end
         ecpa_pkg::ST_EU_MUL: begin
            cnt_in    = last ? '0 : cnt_ff + 1'b1;
            mm_acc_in = mm_acc_nx;
            mm_x_in   = mm_x_nx;
            mm_y_in   = mm_y_nx;
            if (last) begin
               t0_in = t1_ff;
               t1_in = ecpa_pkg::mod_sub(t0_ff, mm_acc_nx, p_ff);
            end
         end
         ecpa_pkg::ST_LAMBDA: begin
            cnt_in    = last ? '0 : cnt_ff + 1'b1;
            mm_acc_in = mm_acc_nx;
            mm_x_in   = mm_x_nx;
            mm_y_in   = mm_y_nx;
            if (last) begin
               lam_in    = mm_acc_nx;
               mm_x_in   = mm_acc_nx;
               mm_y_in   = mm_acc_nx;
               mm_acc_in = '0;
            end
         end
         ecpa_pkg::ST_LAMBDA_SQ: begin
            cnt_in    = last ? '0 : cnt_ff + 1'b1;
            mm_acc_in = mm_acc_nx;
            mm_x_in   = mm_x_nx;
            mm_y_in   = mm_y_nx;
            if (last) begin
               x3_in     = x3_v;
               mm_x_in   = lam_ff;
               mm_y_in   = ecpa_pkg::mod_sub(x1, x3_v, p_ff);
               mm_acc_in = '0;
            end
         end
         ecpa_pkg::ST_Y_MUL: begin
            cnt_in    = last ? '0 : cnt_ff + 1'b1;
            mm_acc_in = mm_acc_nx;
            mm_x_in   = mm_x_nx;
            mm_y_in   = mm_y_nx;
            if (last) begin
               y3_in = ecpa_pkg::mod_sub(mm_acc_nx, y1, p_ff);
            end
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ecpa_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      in_ff      <= in_in;
      p_ff       <= p_in;
      red_ff     <= red_in;
      red_idx_ff <= red_idx_in;
      dv_rem_ff  <= dv_rem_in;
      dv_quo_ff  <= dv_quo_in;
      mm_acc_ff  <= mm_acc_in;
      mm_x_ff    <= mm_x_in;
      mm_y_ff    <= mm_y_in;
      num_ff     <= num_in;
      lam_ff     <= lam_in;
      r0_ff      <= r0_in;
      r1_ff      <= r1_in;
      t0_ff      <= t0_in;
      t1_ff      <= t1_in;
      x3_ff      <= x3_in;
      y3_ff      <= y3_in;
      inf_ff     <= inf_in;
      noinv_ff   <= noinv_in;
      if (rsp_load) begin
         rsp_ff.sum_x       <= x3_ff;
         rsp_ff.sum_y       <= y3_ff;
         rsp_ff.at_infinity <= inf_ff;
         rsp_ff.no_inverse  <= noinv_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

@@ src/ec_point_add_prime_field.sv @@
// sequence: pop, reduce of the five inputs mod p, classify, square (doubling only),
//   extended euclid with a divide and a multiply per quotient step, lambda multiply,
//   lambda square, y multiply, output
// throughput: one transaction at a time in the bit-serial divider and multiplier;
//   a two-entry queue takes new points meanwhile
// reset: synchronous, clears queue, sequencer and output valid; a = 0, p = 65521
`default_nettype none
module ec_point_add_prime_field #(
   parameter int QUEUE_DEPTH = ecpa_pkg::QUEUE_DEPTH
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire ecpa_pkg::req_type                    req_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output ecpa_pkg::rsp_type                         rsp_data,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [ecpa_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire ecpa_pkg::coord_type                  csr_wdata
);

   ecpa_pkg::coord_type coeff_a_ff, modulus_ff;
   logic item_valid, item_pop;
   ecpa_pkg::req_type item_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_a_ff <= ecpa_pkg::COEFF_A_RESET;
         modulus_ff <= ecpa_pkg::MODULUS_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            ecpa_pkg::CSR_COEFF_A: coeff_a_ff <= csr_wdata;
            ecpa_pkg::CSR_MODULUS: modulus_ff <= csr_wdata;
            default: begin
               coeff_a_ff <= coeff_a_ff;
            end
         endcase
      end
   end

   ecpa_front #(
      .DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .item_valid (item_valid),
      .item_data  (item_data),
      .item_pop   (item_pop)
   );

   ecpa_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_data  (item_data),
      .item_pop   (item_pop),
      .coeff_a    (coeff_a_ff),
      .modulus    (modulus_ff),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire
